### rtl/core/srrip_pkg.sv
// shared types, codes and default sizes for the signature rrip replacement block
package srrip_pkg;

  localparam int SETS_DEF      = 2048;
  localparam int WAYS_DEF      = 16;
  localparam int SIG_BITS_DEF  = 14;
  localparam int CTR_BITS_DEF  = 3;
  localparam int AGE_BITS_DEF  = 2;

  localparam int SET_IDX_W = 11;
  localparam int WAY_W     = 4;
  localparam int PC_W      = 16;
  localparam int AGE_OUT_W = 2;
  localparam int LIMIT_W   = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [LIMIT_W-1:0] BAND_ONE_RST   = 3'd2;
  localparam logic [LIMIT_W-1:0] BAND_TWO_RST   = 3'd4;
  localparam logic [LIMIT_W-1:0] BAND_THREE_RST = 3'd6;

  typedef enum logic {
    OP_VICTIM = 1'b0,
    OP_ACCESS = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND_ONE   = 2'd0,
    CFG_BAND_TWO   = 2'd1,
    CFG_BAND_THREE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    op_t                  operation;
    logic [SET_IDX_W-1:0] set_index;
    logic [WAY_W-1:0]     way;
    logic [PC_W-1:0]      pc;
    logic                 hit;
  } req_t;

  typedef struct packed {
    logic [WAY_W-1:0]     victim_way;
    logic [AGE_OUT_W-1:0] insert_age;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_ROW,
    ST_CTR
  } state_t;

endpackage

### rtl/core/signature_rrip_replacement.sv
// top level of the signature based rrip replacement policy
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | srrip_pkg::req_t
//   rsp     | out       | rsp_valid / rsp_ready  | srrip_pkg::rsp_t
//   cfg     | in        | cfg_we                 | cfg_index, cfg_data
//
// victims, hits and out of range ways: result registered from ST_ROW when the slot is free
// miss fills: ST_ROW reads the reuse counters; the result is registered from ST_CTR
// a set count that is not a power of two below 2048 adds ST_ADDR for the set reduction
// one item at a time around the row memory read-modify-write; the next item is taken
// the cycle after a result is registered, even while it waits on rsp_ready
// after reset a sweep that clears every row and reuse counter entry
// runs with req_ready low; configuration writes are taken throughout
module signature_rrip_replacement #(
  parameter int SETS           = srrip_pkg::SETS_DEF,
  parameter int WAYS           = srrip_pkg::WAYS_DEF,
  parameter int SIGNATURE_BITS = srrip_pkg::SIG_BITS_DEF,
  parameter int COUNTER_BITS   = srrip_pkg::CTR_BITS_DEF,
  parameter int AGE_BITS       = srrip_pkg::AGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  srrip_pkg::req_t                     req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output srrip_pkg::rsp_t                     rsp,
  input  logic                                cfg_we,
  input  logic [srrip_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srrip_pkg::LIMIT_W-1:0]       cfg_data
);

  localparam int SIG_COUNT  = 1 << SIGNATURE_BITS;
  localparam int SET_BITS   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WIDX_W     = $clog2(WAYS);
  localparam int CLR_DEPTH  = (SETS > SIG_COUNT) ? SETS : SIG_COUNT;
  localparam int CLR_W      = $clog2(CLR_DEPTH);
  localparam int CMP_W      = (COUNTER_BITS > srrip_pkg::LIMIT_W) ? COUNTER_BITS
                                                                  : srrip_pkg::LIMIT_W;
  localparam bit SET_POW2   = (SETS & (SETS - 1)) == 0;
  localparam bit SET_DIRECT = SET_POW2 || (SETS >= (1 << srrip_pkg::SET_IDX_W));
  localparam int DIV_K      = srrip_pkg::SET_IDX_W + SET_BITS;
  localparam int RECIP      = ((1 << DIV_K) + SETS - 1) / SETS;
  localparam int RECIP_W    = DIV_K + 1;
  localparam int PROD_W     = srrip_pkg::SET_IDX_W + RECIP_W;

  localparam logic [AGE_BITS-1:0]     AGE_TOP  = '1;
  localparam logic [COUNTER_BITS-1:0] CTR_TOP  = '1;
  localparam logic [CLR_W-1:0]        CLR_LAST = CLR_W'(CLR_DEPTH - 1);

  typedef struct packed {
    logic [WAYS-1:0]                     vld;
    logic [WAYS-1:0]                     refd;
    logic [WAYS-1:0][SIGNATURE_BITS-1:0] sig;
    logic [WAYS-1:0][AGE_BITS-1:0]       age;
  } row_t;

  srrip_pkg::state_t state, state_next;

  logic [CLR_W-1:0]              clr_cnt;
  logic [srrip_pkg::LIMIT_W-1:0] band_one, band_two, band_three;

  srrip_pkg::req_t       req_q;
  logic [SET_BITS-1:0]   set_calc;
  logic [SET_BITS-1:0]   set_q;

  row_t                  row_mem [SETS];
  row_t                  row_q;
  logic                  row_re, row_we;
  logic [SET_BITS-1:0]   row_waddr;
  row_t                  row_wdata;

  logic [COUNTER_BITS-1:0]   ctr_mem [SIG_COUNT];
  logic [COUNTER_BITS-1:0]   ctr_a_q, ctr_b_q;
  logic                      ctr_re, ctr_we;
  logic [SIGNATURE_BITS-1:0] ctr_waddr;
  logic [COUNTER_BITS-1:0]   ctr_wdata;

  logic                  accept;
  logic                  slot_free;
  logic                  rsp_load;
  srrip_pkg::rsp_t       rsp_next;

  logic                      way_ok, is_victim, is_hit, is_fill;
  logic [WIDX_W-1:0]         widx;
  logic [srrip_pkg::PC_W-1:0] pc_shift;
  logic [SIGNATURE_BITS-1:0] new_sig, old_sig;
  logic                      old_vld, old_ref;
  logic [COUNTER_BITS-1:0]   ctr_upd, ctr_use;
  logic [AGE_BITS-1:0]       fill_age;
  logic [WAYS-1:0][AGE_BITS-1:0] aged;
  logic [WIDX_W-1:0]         victim_idx;
  row_t                      row_clear;

  assign accept    = req_valid && req_ready;
  assign slot_free = !rsp_valid || rsp_ready;

  // set reduction
  generate
    if (SETS == 1) begin : g_set_one
      assign set_calc = '0;
    end else if (SET_DIRECT) begin : g_set_direct
      assign set_calc = SET_BITS'(req.set_index);
    end else begin : g_set_mod
      logic [PROD_W-1:0]              prod;
      logic [srrip_pkg::SET_IDX_W-1:0] quot_q;
      logic [srrip_pkg::SET_IDX_W-1:0] qd;
      assign prod = PROD_W'(req.set_index) * PROD_W'(RECIP);
      always_ff @(posedge clk) begin
        if (accept) begin
          quot_q <= prod[DIV_K +: srrip_pkg::SET_IDX_W];
        end
      end
      assign qd       = quot_q * srrip_pkg::SET_IDX_W'(SETS);
      assign set_calc = SET_BITS'(req_q.set_index - qd);
    end
  endgenerate

  // item decode
  assign way_ok    = 32'(req_q.way) < 32'(WAYS);
  assign widx      = WIDX_W'(req_q.way);
  assign is_victim = req_q.operation == srrip_pkg::OP_VICTIM;
  assign is_hit    = !is_victim && way_ok && req_q.hit;
  assign is_fill   = !is_victim && way_ok && !req_q.hit;
  assign pc_shift  = req_q.pc >> 2;
  assign new_sig   = SIGNATURE_BITS'(pc_shift);
  assign old_sig   = row_q.sig[widx];
  assign old_vld   = row_q.vld[widx];
  assign old_ref   = row_q.refd[widx];

  srrip_victim #(
    .WAYS     (WAYS),
    .AGE_BITS (AGE_BITS)
  ) u_victim (
    .ages   (row_q.age),
    .aged   (aged),
    .victim (victim_idx)
  );

  // counter training and insertion age
  always_comb begin
    if (old_ref) begin
      ctr_upd = (ctr_a_q == CTR_TOP) ? ctr_a_q : ctr_a_q + COUNTER_BITS'(1);
    end else begin
      ctr_upd = (ctr_a_q == '0) ? ctr_a_q : ctr_a_q - COUNTER_BITS'(1);
    end
    ctr_use = (old_vld && old_sig == new_sig) ? ctr_upd : ctr_b_q;
  end

  always_comb begin
    priority if (CMP_W'(ctr_use) < CMP_W'(band_one)) begin
      fill_age = AGE_TOP;
    end else if (CMP_W'(ctr_use) < CMP_W'(band_two)) begin
      fill_age = AGE_TOP - AGE_BITS'(1);
    end else if (CMP_W'(ctr_use) < CMP_W'(band_three)) begin
      fill_age = AGE_TOP - AGE_BITS'(2);
    end else begin
      fill_age = '0;
    end
  end

  always_comb begin
    row_clear     = '0;
    row_clear.age = '1;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      srrip_pkg::ST_CLEAR: begin
        if (clr_cnt == CLR_LAST) state_next = srrip_pkg::ST_IDLE;
      end
      srrip_pkg::ST_IDLE: begin
        if (req_valid) state_next = SET_DIRECT ? srrip_pkg::ST_ROW : srrip_pkg::ST_ADDR;
      end
      srrip_pkg::ST_ADDR: begin
        state_next = srrip_pkg::ST_ROW;
      end
      srrip_pkg::ST_ROW: begin
        if (is_fill) begin
          state_next = srrip_pkg::ST_CTR;
        end else if (slot_free) begin
          state_next = srrip_pkg::ST_IDLE;
        end
      end
      srrip_pkg::ST_CTR: begin
        if (slot_free) state_next = srrip_pkg::ST_IDLE;
      end
      default: state_next = srrip_pkg::ST_CLEAR;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    req_ready = 1'b0;
    row_re    = 1'b0;
    row_we    = 1'b0;
    row_waddr = set_q;
    row_wdata = row_q;
    ctr_re    = 1'b0;
    ctr_we    = 1'b0;
    ctr_waddr = old_sig;
    ctr_wdata = ctr_upd;
    rsp_load  = 1'b0;
    rsp_next  = '0;
    unique case (state)
      srrip_pkg::ST_CLEAR: begin
        row_we    = {1'b0, clr_cnt} < (CLR_W + 1)'(SETS);
        row_waddr = (SETS > 1) ? clr_cnt[SET_BITS-1:0] : '0;
        row_wdata = row_clear;
        ctr_we    = {1'b0, clr_cnt} < (CLR_W + 1)'(SIG_COUNT);
        ctr_waddr = clr_cnt[SIGNATURE_BITS-1:0];
        ctr_wdata = '0;
      end
      srrip_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        row_re    = SET_DIRECT && req_valid;
      end
      srrip_pkg::ST_ADDR: begin
        row_re = 1'b1;
      end
      srrip_pkg::ST_ROW: begin
        if (is_fill) begin
          ctr_re = 1'b1;
        end else if (slot_free) begin
          rsp_load = 1'b1;
          if (is_victim) begin
            row_we              = 1'b1;
            row_wdata.age       = aged;
            rsp_next.victim_way = srrip_pkg::WAY_W'(victim_idx);
          end else if (is_hit) begin
            row_we               = 1'b1;
            row_wdata.age[widx]  = '0;
            row_wdata.refd[widx] = 1'b1;
          end
        end
      end
      srrip_pkg::ST_CTR: begin
        if (slot_free) begin
          rsp_load             = 1'b1;
          rsp_next.insert_age  = srrip_pkg::AGE_OUT_W'(fill_age);
          row_we               = 1'b1;
          row_wdata.age[widx]  = fill_age;
          row_wdata.sig[widx]  = new_sig;
          row_wdata.refd[widx] = 1'b0;
          row_wdata.vld[widx]  = 1'b1;
          ctr_we               = old_vld;
        end
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= srrip_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == srrip_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band_one   <= srrip_pkg::BAND_ONE_RST;
      band_two   <= srrip_pkg::BAND_TWO_RST;
      band_three <= srrip_pkg::BAND_THREE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srrip_pkg::CFG_BAND_ONE:   band_one   <= cfg_data;
        srrip_pkg::CFG_BAND_TWO:   band_two   <= cfg_data;
        srrip_pkg::CFG_BAND_THREE: band_three <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (row_re) begin
      set_q <= set_calc;
    end
  end

  // row memory
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (row_re) begin
      row_q <= row_mem[set_calc];
    end
  end

  // reuse counter memory
  always_ff @(posedge clk) begin
    if (ctr_we) begin
      ctr_mem[ctr_waddr] <= ctr_wdata;
    end
    if (ctr_re) begin
      ctr_a_q <= ctr_mem[old_sig];
      ctr_b_q <= ctr_mem[new_sig];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req_ready)
    else $error("item accepted while another is in flight");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == srrip_pkg::ST_ROW || state == srrip_pkg::ST_CTR))
    else $error("result raised outside a finishing state");

  a_ctr_write: assert property (@(posedge clk) disable iff (rst)
    ctr_we |-> (state == srrip_pkg::ST_CLEAR || state == srrip_pkg::ST_CTR))
    else $error("counter written outside clear or fill");

  a_ctr_entry: assert property (@(posedge clk) disable iff (rst)
    (state == srrip_pkg::ST_CTR) |->
      $past(state == srrip_pkg::ST_ROW || state == srrip_pkg::ST_CTR))
    else $error("counter stage entered without a row read");
`endif

endmodule

### rtl/core/srrip_victim.sv
// victim way search and set ageing over one row of way ages
module srrip_victim #(
  parameter int WAYS     = srrip_pkg::WAYS_DEF,
  parameter int AGE_BITS = srrip_pkg::AGE_BITS_DEF
) (
  input  logic [WAYS-1:0][AGE_BITS-1:0] ages,
  output logic [WAYS-1:0][AGE_BITS-1:0] aged,
  output logic [$clog2(WAYS)-1:0]       victim
);

  localparam int LEVELS = 1 << AGE_BITS;
  localparam int WIDX_W = $clog2(WAYS);
  localparam logic [AGE_BITS-1:0] AGE_TOP = '1;

  logic [LEVELS-1:0]   level_seen;
  logic [AGE_BITS-1:0] top;
  logic [AGE_BITS-1:0] gap;

  always_comb begin
    level_seen = '0;
    for (int v = 0; v < LEVELS; v++) begin
      for (int w = 0; w < WAYS; w++) begin
        if (ages[w] == AGE_BITS'(v)) begin
          level_seen[v] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    top = '0;
    for (int v = 0; v < LEVELS; v++) begin
      if (level_seen[v]) begin
        top = AGE_BITS'(v);
      end
    end
  end

  assign gap = AGE_TOP - top;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      aged[w] = ages[w] + gap;
    end
  end

  // lowest way at the set maximum
  always_comb begin
    victim = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (ages[w] == top) begin
        victim = WIDX_W'(w);
      end
    end
  end

endmodule
